FILE: rtl/ared_pkg.sv
// Shared types and constants for the adaptive Rice delta encoder.
// No dependencies; used by every module under rtl.
package ared_pkg;

   localparam int WORD_BITS_DEF   = 64;
   localparam int CHANNELS_DEF    = 3;
   localparam int PACKED_W        = 64;
   localparam int SAMPLE_W        = 8;
   localparam int SYM_W           = 9;
   localparam int ERR_W           = 9;
   localparam int K_W             = 4;
   localparam int LEN_W           = 4;
   localparam int ROW_PIX_W       = 16;
   localparam int ROW_POS_W       = 18;
   localparam int MAX_RESULTS     = 10;
   localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
   localparam logic [ROW_PIX_W-1:0] ROW_PIXELS_RESET = 16'd640;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                end_of_image;
   } req_type;

   typedef struct packed {
      logic [PACKED_W-1:0] packed_word;
      logic                last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ZERO,
      ST_TAIL,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      PK_HOLD,
      PK_LOAD,
      PK_ZERO,
      PK_TAIL,
      PK_CLEAR
   } pack_op_type;

   typedef struct packed {
      pack_op_type      op;
      logic [SYM_W-1:0] sym;
      logic [K_W-1:0]   k;
   } pack_ctl_type;

   typedef struct packed {
      logic free_zero;
      logic zeros_done;
      logic tail_fits;
   } pack_sts_type;

endpackage

FILE: rtl/ared_ctx.sv
// Prediction context: previous sample, error estimate and row position.
// Forms the zigzag symbol and Rice parameter; depends on ared_pkg.
module ared_ctx #(
   parameter int CHANNELS = ared_pkg::CHANNELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [ared_pkg::SAMPLE_W-1:0]      sample,
   input  logic                               eoi,
   input  logic [ared_pkg::ROW_PIX_W-1:0]     row_pixels,
   output logic [ared_pkg::SYM_W-1:0]         sym,
   output logic [ared_pkg::K_W-1:0]           k
);

   localparam int RW = ared_pkg::ROW_POS_W;

   logic [ared_pkg::SAMPLE_W-1:0]  prev_ff, prev_in;
   logic [ared_pkg::ERR_W-1:0]     err_ff, err_in;
   logic [RW-1:0]                  pos_ff, pos_in;

   logic [ared_pkg::SAMPLE_W:0]    resid;
   logic [ared_pkg::SYM_W-1:0]     dbl;
   logic [ared_pkg::ERR_W:0]       err_p1;
   logic [11:0]                    err_sum;
   logic [RW-1:0]                  pos_next;
   logic [RW-1:0]                  row_limit;

   // index of the highest set bit
   function automatic logic [ared_pkg::K_W-1:0] msb_index(input logic [ared_pkg::ERR_W:0] v);
      logic [ared_pkg::K_W-1:0] r;
      r = '0;
      for (int i = 1; i <= ared_pkg::ERR_W; i++) begin
         if (v[i]) begin
            r = ared_pkg::K_W'(i);
         end
      end
      return r;
   endfunction

   always_comb begin
      resid     = {1'b0, sample} - {1'b0, prev_ff};
      dbl       = {resid[ared_pkg::SAMPLE_W-1:0], 1'b0};
      sym       = resid[ared_pkg::SAMPLE_W] ? ~dbl : dbl;
      err_p1    = {1'b0, err_ff} + 1'b1;
      k         = msb_index(err_p1);
      err_sum   = (12'(err_ff) << 1) + 12'(err_ff) + 12'(sym);
      pos_next  = pos_ff + 1'b1;
      row_limit = RW'(row_pixels) * RW'(CHANNELS);

      prev_in = prev_ff;
      err_in  = err_ff;
      pos_in  = pos_ff;
      if (load) begin
         if (eoi || (pos_next >= row_limit)) begin
            prev_in = '0;
            err_in  = '0;
            pos_in  = '0;
         end else begin
            prev_in = sample;
            err_in  = err_sum[ared_pkg::ERR_W+1:2];
            pos_in  = pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         err_ff  <= '0;
         pos_ff  <= '0;
      end else begin
         prev_ff <= prev_in;
         err_ff  <= err_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

FILE: rtl/ared_pack.sv
// Bit packer: the shared shift/merge unit that lays code bits into the cache word.
// Places a run of zeros or a slice of the stop+suffix field per step; depends on ared_pkg.
module ared_pack #(
   parameter int WORD_BITS = ared_pkg::WORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ared_pkg::pack_ctl_type ctl,
   output ared_pkg::pack_sts_type sts,
   output logic [WORD_BITS-1:0]   word
);

   localparam int FREE_W = $clog2(WORD_BITS + 1);
   localparam int SW     = ared_pkg::SYM_W;
   localparam int LW     = ared_pkg::LEN_W;
   localparam int CMP_W  = (FREE_W > SW) ? FREE_W : SW;

   logic [WORD_BITS-1:0] cache_ff, cache_in;
   logic [FREE_W-1:0]    free_ff, free_in;
   logic [SW-1:0]        zrem_ff, zrem_in;
   logic [SW-1:0]        tval_ff, tval_in;
   logic [LW-1:0]        tlen_ff, tlen_in;

   logic [CMP_W-1:0]     free_ext, zrem_ext, tlen_ext, zstep;
   logic [LW-1:0]        spill;

   function automatic logic [SW-1:0] low_mask(input logic [LW-1:0] n);
      logic [SW:0] bit_n;
      bit_n = (SW + 1)'(1) << n;
      return SW'(bit_n - 1'b1);
   endfunction

   always_comb begin
      free_ext = CMP_W'(free_ff);
      zrem_ext = CMP_W'(zrem_ff);
      tlen_ext = CMP_W'(tlen_ff);
      zstep    = (zrem_ext < free_ext) ? zrem_ext : free_ext;
      spill    = tlen_ff - LW'(free_ff);

      sts.free_zero  = (free_ff == '0);
      sts.zeros_done = (zrem_ff == '0);
      sts.tail_fits  = (tlen_ext <= free_ext);

      cache_in = cache_ff;
      free_in  = free_ff;
      zrem_in  = zrem_ff;
      tval_in  = tval_ff;
      tlen_in  = tlen_ff;

      case (ctl.op)
         ared_pkg::PK_LOAD: begin
            zrem_in = ctl.sym >> ctl.k;
            tlen_in = LW'(ctl.k) + 1'b1;
            tval_in = (ctl.sym & low_mask(LW'(ctl.k))) | (SW'(1) << ctl.k);
         end
         ared_pkg::PK_ZERO: begin
            free_in = free_ff - FREE_W'(zstep);
            zrem_in = zrem_ff - SW'(zstep);
         end
         ared_pkg::PK_TAIL: begin
            if (sts.tail_fits) begin
               cache_in = cache_ff
                        | (WORD_BITS'(tval_ff) << (free_ff - FREE_W'(tlen_ff)));
               free_in  = free_ff - FREE_W'(tlen_ff);
               tlen_in  = '0;
            end else begin
               // word ends inside the field: top bits now, the rest next word
               cache_in = cache_ff | WORD_BITS'(tval_ff >> spill);
               tval_in  = tval_ff & low_mask(spill);
               tlen_in  = spill;
               free_in  = '0;
            end
         end
         ared_pkg::PK_CLEAR: begin
            cache_in = '0;
            free_in  = FREE_W'(WORD_BITS);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cache_ff <= '0;
         free_ff  <= FREE_W'(WORD_BITS);
      end else begin
         cache_ff <= cache_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      zrem_ff <= zrem_in;
      tval_ff <= tval_in;
      tlen_ff <= tlen_in;
   end

   assign word = cache_ff;

endmodule

FILE: rtl/adaptive_rice_delta_encoder.sv
// Adaptive Rice delta encoder, top level: sequencer, output register, row length CSR.
// Depends on ared_pkg, ared_ctx and ared_pack.
//
// Usage:
//   req_*  : one sample byte per word (req_data.sample) with end_of_image on
//            the final byte of an image. req_ready is high only while idle
//            and out of reset.
//   rsp_*  : 64-bit code words, first code bit in bit WORD_BITS-1; rsp_data.last
//            marks the flushed final word of an image (unused bits zero).
//   csr_*  : row_pixels write port, ready whenever out of reset; write only
//            while idle.
// Sequence: a sample is accepted and loaded in idle, then the packer places
//   its run of zeros in steps of at most the free space of the current word and
//   closes the run; it then places the stop bit and suffix, split across a
//   word boundary when needed, emits each full word before placing more bits
//   and closes the sample before idle takes the next one. The shared packer
//   places at most one word's worth of bits per cycle while not held by a full word.
// Reset: cache empty, prediction and error estimate zero, row_pixels = 640.
// Stall: a full word waits in the packer while the output register is held;
//   coding of the sample resumes when rsp_ready takes the previous word.
module adaptive_rice_delta_encoder #(
   parameter int WORD_BITS = ared_pkg::WORD_BITS_DEF,
   parameter int CHANNELS  = ared_pkg::CHANNELS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ared_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ared_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ared_pkg::ROW_PIX_W-1:0] csr_data
);

   localparam int CW = ared_pkg::CNT_W;

   ared_pkg::state_type               state_ff, state_in;
   logic                              eoi_ff, eoi_in;
   logic [CW-1:0]                     cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   ared_pkg::rsp_type                 rsp_data_ff, rsp_data_in;
   logic [ared_pkg::ROW_PIX_W-1:0]    row_pixels_ff;

   logic                              accept;
   logic                              slot_free, drop, emit_go;
   logic [ared_pkg::SYM_W-1:0]        sym;
   logic [ared_pkg::K_W-1:0]          k;
   ared_pkg::pack_ctl_type            pk_ctl;
   ared_pkg::pack_sts_type            pk_sts;
   logic [WORD_BITS-1:0]              word;

   assign req_ready = !reset && (state_ff == ared_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ared_ctx #(
      .CHANNELS (CHANNELS)
   ) u_ctx (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .sample     (req_data.sample),
      .eoi        (req_data.end_of_image),
      .row_pixels (row_pixels_ff),
      .sym        (sym),
      .k          (k)
   );

   ared_pack #(
      .WORD_BITS (WORD_BITS)
   ) u_pack (
      .clock (clock),
      .reset (reset),
      .ctl   (pk_ctl),
      .sts   (pk_sts),
      .word  (word)
   );

   always_comb begin
      slot_free = !rsp_valid_ff || rsp_ready;
      drop      = (cnt_ff >= CW'(ared_pkg::MAX_RESULTS));
      emit_go   = drop || slot_free;

      state_in     = state_ff;
      eoi_in       = eoi_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pk_ctl.op    = ared_pkg::PK_HOLD;
      pk_ctl.sym   = sym;
      pk_ctl.k     = k;

      case (state_ff)
         ared_pkg::ST_IDLE: begin
            if (accept) begin
               pk_ctl.op = ared_pkg::PK_LOAD;
               eoi_in    = req_data.end_of_image;
               cnt_in    = '0;
               state_in  = ared_pkg::ST_ZERO;
            end
         end
         ared_pkg::ST_ZERO: begin
            if (!pk_sts.free_zero) begin
               if (pk_sts.zeros_done) begin
                  state_in = ared_pkg::ST_TAIL;
               end else begin
                  pk_ctl.op = ared_pkg::PK_ZERO;
               end
            end
         end
         ared_pkg::ST_TAIL: begin
            if (!pk_sts.free_zero) begin
               pk_ctl.op = ared_pkg::PK_TAIL;
               if (pk_sts.tail_fits) begin
                  state_in = ared_pkg::ST_FINISH;
               end
            end
         end
         ared_pkg::ST_FINISH: begin
            if (!pk_sts.free_zero) begin
               if (!eoi_ff) begin
                  state_in = ared_pkg::ST_IDLE;
               end else if (emit_go) begin
                  // flush the partial word, marked last
                  pk_ctl.op = ared_pkg::PK_CLEAR;
                  state_in  = ared_pkg::ST_IDLE;
                  if (!drop) begin
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.packed_word  = ared_pkg::PACKED_W'(word);
                     rsp_data_in.last         = 1'b1;
                     cnt_in                   = cnt_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ared_pkg::ST_IDLE;
         end
      endcase

      // full word: emit before placing any more bits
      if ((state_ff != ared_pkg::ST_IDLE) && pk_sts.free_zero && emit_go) begin
         pk_ctl.op = ared_pkg::PK_CLEAR;
         if (!drop) begin
            rsp_valid_in            = 1'b1;
            rsp_data_in.packed_word = ared_pkg::PACKED_W'(word);
            rsp_data_in.last        = 1'b0;
            cnt_in                  = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ared_pkg::ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         row_pixels_ff <= ared_pkg::ROW_PIXELS_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            row_pixels_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      eoi_ff      <= eoi_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
